FILE: design/ttbpm_pkg.sv
// Shared types and constants for the tap tempo BPM estimator.
// No dependencies; imported by the top level, controller, datapath and checker.
package ttbpm_pkg;

    localparam int          TS_W         = 32;
    localparam int          RING_DEPTH   = 4;
    localparam int          SLOT_W       = 2;
    localparam int          CHANNELS_DEF = 2;
    localparam logic [31:0] TPM_RESET    = 32'd60000000;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    // divide-by-three of the 34-bit interval sum, four bits per step
    localparam int D3_W     = 36;
    localparam int D3_BITS  = 4;
    localparam int D3_STEPS = D3_W / D3_BITS;

    typedef struct packed {
        logic       load;       // latch the incoming transaction
        logic       fetch;      // read one older stamp from the ring
        logic [1:0] fetch_idx;  // 0 = oldest
        logic       calc;       // form the three intervals
        logic       judge;      // ratio tests, interval sum
        logic       mean_step;  // one step of the divide-by-three
        logic       div_start;  // start ticks_per_minute / mean
        logic       commit;     // update channel state, load result
    } dp_cmd_t;

    typedef struct packed {
        logic proc;      // stamp is new and channel in range
        logic accept;    // intervals agree and mean nonzero
        logic div_done;
        logic out_free;  // result register can take a new result
    } dp_stat_t;

endpackage

FILE: design/tap_tempo_bpm_estimator_top.sv
// Tap tempo BPM estimator. Takes one trigger transaction at a time and returns one result
// for each. A repeated stamp or an unused channel goes from the check straight to commit;
// a new stamp that fails the interval test first passes the three ring memory reads, the
// interval tests and the divide-by-three of the interval sum; a stamp that yields a new
// estimate also runs the radix-2 ticks_per_minute / mean divider. Input is taken again as
// soon as the controller is back in idle, while the previous result may still wait on
// m_tready. A register write is taken only while the controller is idle.
// Depends on ttbpm_pkg, ttbpm_ctrl and ttbpm_dpath.
module tap_tempo_bpm_estimator_top
    import ttbpm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] timestamp
    input  logic                 s_tuser,   // [0] channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] bpm, [63:32] mean_interval,
                                            // [64] active_channel, [71:65] zero
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] channel_out, [1] updated
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // no transaction in flight while the controller sits in idle
    assign cfg_ready = s_tready;

    ttbpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ttbpm_dpath #(
        .CHANNELS (CHANNELS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: design/ttbpm_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ttbpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ttbpm_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Does not use ttbpm_pkg; standalone.
module ttbpm_div #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     q_reg;
    logic [W-1:0]     r_reg;
    logic [W-1:0]     d_reg;
    logic [W:0]       trial;
    logic             ge;
    logic [W-1:0]     r_next;
    logic [W-1:0]     q_next;

    always_comb begin
        trial  = {r_reg, q_reg[W-1]};
        ge     = (trial >= {1'b0, d_reg});
        r_next = ge ? W'(trial - {1'b0, d_reg}) : trial[W-1:0];
        q_next = {q_reg[W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: design/ttbpm_dpath.sv
// Datapath: per-channel state, stamp ring memory, interval maths, result register.
// Depends on ttbpm_pkg, ttbpm_ram and ttbpm_div.
module ttbpm_dpath
    import ttbpm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 cfg_valid,
    input  logic [31:0]          cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RAM_DEPTH = CHANNELS * RING_DEPTH;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    // configuration
    logic [31:0] tpm_reg;

    // per-channel state
    logic [TS_W-1:0]   last_stamp_reg    [CHANNELS];
    logic [SLOT_W-1:0] write_slot_reg    [CHANNELS];
    logic [31:0]       held_bpm_reg      [CHANNELS];
    logic [31:0]       held_interval_reg [CHANNELS];
    logic              active_reg;
    logic [RAM_DEPTH-1:0] ring_vld_reg;

    // current transaction
    logic [CH_IDX_W-1:0] ch_idx_reg;
    logic                ch_reg;
    logic                in_range_reg;
    logic                proc_reg;
    logic [TS_W-1:0]     stamp_reg;
    logic [SLOT_W-1:0]   w_reg;
    logic [CH_IDX_W-1:0] ch_idx_in;
    logic                in_range_in;

    // ring access
    logic [SLOT_W-1:0] rd_slot;
    logic [RAM_AW-1:0] ram_raddr;
    logic [RAM_AW-1:0] ram_waddr;
    logic              ram_we;
    logic [TS_W-1:0]   ram_rdata;
    logic              rd_pend_reg;
    logic              rd_vld_reg;
    logic [TS_W-1:0]   old0_reg, old1_reg, old2_reg;

    // interval maths
    logic [31:0]       i0_reg, i1_reg, i2_reg;
    logic              ok_reg;
    logic              ok_next;
    logic [33:0]       sum_next;
    logic [D3_W-1:0]   d3_q_reg;
    logic [1:0]        d3_r_reg;
    logic [D3_W-1:0]   d3_q_next;
    logic [1:0]        d3_r_next;
    logic              accept;
    logic [31:0]       mean;

    // divider
    logic              div_done;
    logic [31:0]       div_q;

    // result
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic [31:0]          bpm_o;
    logic [31:0]          mean_o;
    logic                 active_o;

    assign ch_idx_in   = CH_IDX_W'(s_tuser);
    assign in_range_in = (int'(s_tuser) < CHANNELS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpm_reg <= TPM_RESET;
        end else if (cfg_valid) begin
            tpm_reg <= cfg_data;
        end
    end

    // latch transaction; the channel's write slot comes along
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proc_reg     <= 1'b0;
            in_range_reg <= 1'b0;
        end else if (cmd.load) begin
            in_range_reg <= in_range_in;
            proc_reg     <= in_range_in && (s_tdata != last_stamp_reg[ch_idx_in]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_idx_reg <= ch_idx_in;
            ch_reg     <= s_tuser;
            stamp_reg  <= s_tdata;
            w_reg      <= in_range_in ? write_slot_reg[ch_idx_in] : '0;
        end
    end

    // oldest to newest: w+1, w+2, w+3, then the new stamp in w
    assign rd_slot   = w_reg + SLOT_W'(cmd.fetch_idx) + SLOT_W'(1);
    assign ram_raddr = RAM_AW'({ch_idx_reg, rd_slot});
    assign ram_waddr = RAM_AW'({ch_idx_reg, w_reg});
    assign ram_we    = cmd.fetch && (cmd.fetch_idx == 2'd0);

    ttbpm_ram #(
        .WIDTH (TS_W),
        .DEPTH (RAM_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (stamp_reg),
        .re    (cmd.fetch),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // never-written ring entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg <= '0;
            rd_pend_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.fetch;
            if (cmd.fetch) begin
                rd_vld_reg <= ring_vld_reg[ram_raddr];
            end
            if (ram_we) begin
                ring_vld_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_pend_reg) begin
            old0_reg <= old1_reg;
            old1_reg <= old2_reg;
            old2_reg <= rd_vld_reg ? ram_rdata : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            i0_reg <= old1_reg - old0_reg;
            i1_reg <= old2_reg - old1_reg;
            i2_reg <= stamp_reg - old2_reg;
        end
    end

    // 4*a < 5*b in 35 bits
    always_comb begin
        ok_next = ({1'b0, i1_reg, 2'b00} < ({1'b0, i0_reg, 2'b00} + 35'(i0_reg)))
               && ({1'b0, i2_reg, 2'b00} < ({1'b0, i0_reg, 2'b00} + 35'(i0_reg)))
               && ({1'b0, i0_reg, 2'b00} < ({1'b0, i2_reg, 2'b00} + 35'(i2_reg)));
        sum_next = 34'(i0_reg) + 34'(i1_reg) + 34'(i2_reg);
    end

    // long division by three, MSB first, remainder stays in 0..2
    always_comb begin
        logic [2:0] t;
        logic       qb;
        d3_q_next = d3_q_reg;
        d3_r_next = d3_r_reg;
        for (int j = 0; j < D3_BITS; j++) begin
            t  = {d3_r_next, d3_q_next[D3_W-1]};
            qb = (t >= 3'd3);
            if (qb) begin
                t = t - 3'd3;
            end
            d3_r_next = t[1:0];
            d3_q_next = {d3_q_next[D3_W-2:0], qb};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg <= 1'b0;
        end else if (cmd.judge) begin
            ok_reg <= ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.judge) begin
            d3_q_reg <= D3_W'(sum_next);
            d3_r_reg <= 2'd0;
        end else if (cmd.mean_step) begin
            d3_q_reg <= d3_q_next;
            d3_r_reg <= d3_r_next;
        end
    end

    assign mean   = d3_q_reg[31:0];
    assign accept = proc_reg && ok_reg && (d3_q_reg != '0);

    ttbpm_div #(
        .W (32)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (tpm_reg),
        .divisor  (mean),
        .done     (div_done),
        .quotient (div_q)
    );

    // result values after this transaction's update
    always_comb begin
        bpm_o    = '0;
        mean_o   = '0;
        active_o = accept ? ch_reg : active_reg;
        if (accept) begin
            bpm_o  = div_q;
            mean_o = mean;
        end else if (in_range_reg) begin
            bpm_o  = held_bpm_reg[ch_idx_reg];
            mean_o = held_interval_reg[ch_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                last_stamp_reg[c]    <= '0;
                write_slot_reg[c]    <= '0;
                held_bpm_reg[c]      <= '0;
                held_interval_reg[c] <= '0;
            end
            active_reg <= 1'b0;
        end else if (cmd.commit) begin
            if (proc_reg) begin
                last_stamp_reg[ch_idx_reg] <= stamp_reg;
                write_slot_reg[ch_idx_reg] <= w_reg + SLOT_W'(1);
            end
            if (accept) begin
                held_bpm_reg[ch_idx_reg]      <= div_q;
                held_interval_reg[ch_idx_reg] <= mean;
                active_reg                    <= ch_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= {7'd0, active_o, mean_o, bpm_o};
            m_tuser_reg <= {accept, ch_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign stat.proc     = proc_reg;
    assign stat.accept   = accept;
    assign stat.div_done = div_done;
    assign stat.out_free = !m_tvalid_reg || m_tready;

endmodule

FILE: design/ttbpm_ctrl.sv
// Controller: sequences ring fetch, interval tests, mean and BPM division.
// Depends on ttbpm_pkg.
module ttbpm_ctrl
    import ttbpm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_CHECK  = 10'b00_0000_0010,
        ST_FETCH  = 10'b00_0000_0100,
        ST_DRAIN  = 10'b00_0000_1000,
        ST_CALC   = 10'b00_0001_0000,
        ST_JUDGE  = 10'b00_0010_0000,
        ST_MEAN   = 10'b00_0100_0000,
        ST_PREP   = 10'b00_1000_0000,
        ST_DIVIDE = 10'b01_0000_0000,
        ST_COMMIT = 10'b10_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cnt_next   = '0;
                state_next = stat.proc ? ST_FETCH : ST_COMMIT;
            end
            ST_FETCH: begin
                cmd.fetch     = 1'b1;
                cmd.fetch_idx = cnt_reg[1:0];
                cnt_next      = cnt_reg + 4'd1;
                if (cnt_reg == 4'd2) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_JUDGE;
            end
            ST_JUDGE: begin
                cmd.judge  = 1'b1;
                cnt_next   = '0;
                state_next = ST_MEAN;
            end
            ST_MEAN: begin
                cmd.mean_step = 1'b1;
                cnt_next      = cnt_reg + 4'd1;
                if (cnt_reg == 4'(D3_STEPS - 1)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (stat.accept) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIVIDE: begin
                if (stat.div_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: design/ttbpm_checker.sv
// Port-level checks for the tap tempo BPM estimator, bound to the top level.
// Depends on ttbpm_pkg and tap_tempo_bpm_estimator_top.
module ttbpm_checker
    import ttbpm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

    a_update_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata[63:32] != 32'd0))
        else $error("update with zero mean interval");

    a_update_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata[64] == m_tuser[0]))
        else $error("update did not make its channel active");

endmodule

bind tap_tempo_bpm_estimator_top ttbpm_checker u_checker (.*);

FILE: tb/sv/ttbpm_tempo_checker.sv
// Scoreboard for the tap tempo BPM estimator: follows the trigger, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on ttbpm_pkg for the stream widths and the ring depth.
module ttbpm_tempo_checker
    import ttbpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [31:0]          cfg_data,
    output int                   pending_count,
    output int                   mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH = 2;

    typedef struct packed {
        logic        channel;
        logic        updated;
        logic [31:0] bpm;
        logic [31:0] mean_interval;
        logic        active;
    } tempo_result_t;

    logic [31:0]   stamp_hist    [NUM_CH][RING_DEPTH];
    logic [1:0]    next_slot     [NUM_CH];
    logic [31:0]   prev_stamp    [NUM_CH];
    logic [31:0]   bpm_held      [NUM_CH];
    logic [31:0]   interval_held [NUM_CH];
    logic          active_ch;
    logic [31:0]   tick_rate;
    tempo_result_t tempo_queue   [$];

    initial begin
        pending_count  = 0;
        mismatch_count = 0;
    end

    // one trigger through the estimator: ring update, interval tests, held values
    task automatic estimate_tempo(input logic ch, input logic [31:0] ts,
                                  output tempo_result_t res);
        logic [1:0]  w;
        logic [1:0]  s1;
        logic [1:0]  s2;
        logic [1:0]  s3;
        logic [31:0] i0;
        logic [31:0] i1;
        logic [31:0] i2;
        logic [33:0] total;
        logic [33:0] mean;
        logic        agree;
        res         = '0;
        res.channel = ch;
        if (ts != prev_stamp[ch]) begin
            w  = next_slot[ch];
            s1 = w + 2'd1;
            s2 = w + 2'd2;
            s3 = w + 2'd3;
            stamp_hist[ch][w] = ts;
            // oldest to newest: s1, s2, s3, w; differences wrap modulo 2^32
            i0 = stamp_hist[ch][s2] - stamp_hist[ch][s1];
            i1 = stamp_hist[ch][s3] - stamp_hist[ch][s2];
            i2 = stamp_hist[ch][w]  - stamp_hist[ch][s3];
            agree = ({3'b0, i1} * 35'd4 < {3'b0, i0} * 35'd5)
                 && ({3'b0, i2} * 35'd4 < {3'b0, i0} * 35'd5)
                 && ({3'b0, i0} * 35'd4 < {3'b0, i2} * 35'd5);
            total = {2'b0, i0} + {2'b0, i1} + {2'b0, i2};
            mean  = total / 34'd3;
            if (agree && mean != '0) begin
                interval_held[ch] = mean[31:0];
                bpm_held[ch]      = tick_rate / mean[31:0];
                active_ch         = ch;
                res.updated       = 1'b1;
            end
            prev_stamp[ch] = ts;
            next_slot[ch]  = w + 2'd1;
        end
        res.bpm           = bpm_held[ch];
        res.mean_interval = interval_held[ch];
        res.active        = active_ch;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        tempo_result_t want;
        tempo_result_t got;
        if (!aresetn) begin
            for (int c = 0; c < NUM_CH; c++) begin
                for (int k = 0; k < RING_DEPTH; k++)
                    stamp_hist[c][k] = '0;
                next_slot[c]     = '0;
                prev_stamp[c]    = '0;
                bpm_held[c]      = '0;
                interval_held[c] = '0;
            end
            active_ch = 1'b0;
            tick_rate = TPM_RESET;
            tempo_queue.delete();
        end else begin
            // results before triggers: a result never belongs to a trigger of the same edge
            if (m_tvalid && m_tready) begin
                if (tempo_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t ns: result transaction with nothing outstanding", $time);
                end else begin
                    want = tempo_queue.pop_front();
                    got  = '{channel: m_tuser[0], updated: m_tuser[1],
                             bpm: m_tdata[31:0], mean_interval: m_tdata[63:32],
                             active: m_tdata[64]};
                    check_field("channel_out",    32'(want.channel),  32'(got.channel));
                    check_field("updated",        32'(want.updated),  32'(got.updated));
                    check_field("bpm",            want.bpm,           got.bpm);
                    check_field("mean_interval",  want.mean_interval, got.mean_interval);
                    check_field("active_channel", 32'(want.active),   32'(got.active));
                end
            end
            if (cfg_valid && cfg_ready)
                tick_rate = cfg_data;
            if (s_tvalid && s_tready) begin
                estimate_tempo(s_tuser, s_tdata[31:0], want);
                tempo_queue.push_back(want);
            end
        end
        pending_count <= tempo_queue.size();
    end

endmodule

FILE: tb/sv/tb.sv
// Top of the tap tempo BPM estimator bench: clock, reset, trigger and register stimulus,
// result back-pressure and the verdict. Depends on ttbpm_pkg, the estimator top level
// and ttbpm_tempo_checker, which does all prediction and comparison.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttbpm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int SETTLE_CYCLES   = 60;
    localparam int PHASE_ITEMS     = 366;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [31:0]          cfg_data  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_ready;
    int                   pending_count;
    int                   mismatch_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    // per-channel tap generator: running stamp, current beat, last stamp sent
    logic [31:0] next_stamp [2] = '{32'd0, 32'd0};
    logic [31:0] beat       [2] = '{32'd1000, 32'd1000};
    logic [31:0] sent_stamp [2] = '{32'd0, 32'd0};

    always #2 aclk = ~aclk;

    tap_tempo_bpm_estimator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ttbpm_tempo_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .pending_count  (pending_count),
        .mismatch_count (mismatch_count)
    );

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_OFF_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tap_tempo_bpm_estimator_top verification failed");
            $finish;
        end
    end

    // valid stays high from one transaction to the next unless an idle cycle is drawn
    task automatic send_stamp(input logic ch, input logic [31:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid       <= 1'b1;
        s_tuser        <= ch;
        s_tdata        <= ts;
        sent_stamp[ch] = ts;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic write_tick_rate(input logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct <= stall_pct;
    endtask

    // mostly human tap rates, some tiny beats and some near a third of the stamp range
    function automatic logic [31:0] pick_beat();
        case ($urandom_range(9))
            0:       return $urandom_range(40, 1);
            1:       return $urandom_range(32'h5D00_0000, 32'h4000_0000);
            default: return $urandom_range(2000000, 2000);
        endcase
    endfunction

    task automatic run_taps(input int count);
        logic        ch;
        int          kind;
        logic [31:0] jit;
        repeat (count) begin
            ch   = 1'($urandom_range(1));
            kind = $urandom_range(99);
            if (kind < 70) begin
                // steady beat, jitter well inside the 1.25 window
                jit            = beat[ch] / 8;
                next_stamp[ch] = next_stamp[ch] + beat[ch] - jit / 2 + $urandom_range(jit);
            end else if (kind < 78) begin
                next_stamp[ch] = sent_stamp[ch];
            end else if (kind < 86) begin
                next_stamp[ch] = $urandom;
            end else if (kind < 94) begin
                beat[ch]       = pick_beat();
                next_stamp[ch] = next_stamp[ch] + beat[ch];
            end else begin
                next_stamp[ch] = next_stamp[ch] + $urandom_range(beat[ch] * 2);
            end
            send_stamp(ch, next_stamp[ch]);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // zero stamps straight after reset are repeats
        send_stamp(1'b0, 32'd0);
        send_stamp(1'b1, 32'd0);
        send_stamp(1'b0, 32'd1000);
        send_stamp(1'b0, 32'd2000);
        send_stamp(1'b0, 32'd3000);
        send_stamp(1'b0, 32'd4000);
        send_stamp(1'b0, 32'd4000);
        // one-tick beat: bpm equals the numerator
        send_stamp(1'b1, 32'd5);
        send_stamp(1'b1, 32'd6);
        send_stamp(1'b1, 32'd7);
        send_stamp(1'b1, 32'd8);
        send_stamp(1'b1, 32'd13);
        send_stamp(1'b0, 32'd5000);
        // ratio exactly 1.25 for the last, then the middle interval: rejected both times
        send_stamp(1'b0, 32'd6250);
        send_stamp(1'b0, 32'd7249);
        // beat across the stamp wrap
        send_stamp(1'b1, 32'hFFFF_FFF7);
        send_stamp(1'b1, 32'hFFFF_FFFF);
        send_stamp(1'b1, 32'h0000_0007);
        send_stamp(1'b1, 32'h0000_000F);
        // interval sum beyond 32 bits
        send_stamp(1'b0, 32'h5800_1C51);
        send_stamp(1'b0, 32'hB000_1C51);
        send_stamp(1'b0, 32'h0800_1C51);
        send_stamp(1'b1, 32'h0000_000F);
        drain();

        next_stamp = sent_stamp;
        beat[0]    = pick_beat();
        beat[1]    = pick_beat();

        write_tick_rate(32'hFFFF_FFFF);
        set_idling(0, 0);
        hold_req <= hold_req + 1;
        run_taps(PHASE_ITEMS);

        write_tick_rate(32'd1);
        set_idling(66, 0);
        run_taps(PHASE_ITEMS);

        write_tick_rate(32'd0);
        set_idling(0, 66);
        run_taps(PHASE_ITEMS);

        write_tick_rate($urandom);
        set_idling(36, 36);
        run_taps(PHASE_ITEMS);

        write_tick_rate(TPM_RESET);
        set_idling(0, 0);
        hold_req <= hold_req + 1;
        run_taps(PHASE_ITEMS);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tap_tempo_bpm_estimator_top verification clean");
        else
            $display("tap_tempo_bpm_estimator_top verification failed");
        $finish;
    end

endmodule
